// File: hdl/lfia_pkg.sv
// ----------------------------------------------------------------------------
// Lowest free identifier allocator package
// Shared types and constants for the allocator and its checkers.
// ----------------------------------------------------------------------------
package lfia_pkg;

    localparam int IDENT_W  = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ALLOC    = 2'd1,
        OP_FREE     = 2'd2,
        OP_REGISTER = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_RMW,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [IDENT_W-1:0] ident;
    } request_t;

    typedef struct packed {
        logic [IDENT_W-1:0] granted_ident;
        status_t            status;
    } result_t;

endpackage

// File: hdl/lowest_free_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Lowest free identifier allocator
// Keeps a used-bit map in a word memory and a hint at the lowest free
// identifier; a small sequencer examines one word per cycle while scanning.
// ----------------------------------------------------------------------------
// Free and register pass through the divide and read-modify-write states, an
// out-of-range identifier goes straight to done, clear sweeps every map word
// and allocate scans from the hint. The result strobe rises in the cycle that
// busy falls. Throughput is set by the single read port: one map word is read
// per cycle while scanning. After reset busy stays high for a sweep that zeroes
// the map. The receiver cannot stall; every result is shown for exactly one cycle.
module lowest_free_id_allocator_unit #(
    parameter int ID_COUNT  = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lfia_pkg::request_t request,
    output logic               done,
    output lfia_pkg::result_t  result
);

    import lfia_pkg::*;

    localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SW_W       = $clog2(WORD_COUNT + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int ID_W       = $clog2(ID_COUNT);
    localparam int LAST_WORD  = WORD_COUNT - 1;
    localparam int LAST_VALID = ID_COUNT - LAST_WORD * WORD_BITS;
    localparam int END_WORD   = ID_COUNT / WORD_BITS;
    localparam int END_BIT    = ID_COUNT % WORD_BITS;
    localparam int DIV_SHIFT  = 20;
    localparam int RECIP      = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int PROD_W     = IDENT_W + RECIP_W;

    logic [WORD_BITS-1:0] mem [0:WORD_COUNT-1];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WADDR_W-1:0]   mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    state_t               state_reg, state_next;
    logic                 init_reg, init_next;
    logic [SW_W-1:0]      word_reg, word_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [SW_W-1:0]      hint_word_reg, hint_word_next;
    logic [BIT_W-1:0]     hint_bit_reg, hint_bit_next;
    logic                 grant_phase_reg, grant_phase_next;
    logic                 done_reg, done_next;

    op_t                  op_reg, op_next;
    logic [IDENT_W-1:0]   ident_reg, ident_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SW_W-1:0]      grant_word_reg, grant_word_next;
    logic [BIT_W-1:0]     grant_bit_reg, grant_bit_next;
    logic                 grant_ok_reg, grant_ok_next;
    status_t              status_reg, status_next;
    result_t              result_reg, result_next;

    logic [WORD_BITS-1:0] zero_vec;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic                 word_last;
    logic                 start_out_of_range;
    logic [SW_W-1:0]      quot_word;
    logic [IDENT_W-1:0]   rem_full;
    logic [BIT_W-1:0]     rem_bit;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] hit_mask;
    logic [ID_W-1:0]      grant_id;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        zero_vec = '0;
        hit_bit  = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            zero_vec[i] = ~rdata_reg[i]
                          & ~((word_reg == SW_W'(LAST_WORD)) && (i >= LAST_VALID))
                          & ~((word_reg == '0) && (i == 0))
                          & ~(i < int'(bit_reg));
        end
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (zero_vec[i])
            begin
                hit_bit = BIT_W'(i);
            end
        end
        hit = |zero_vec;
    end

    assign word_last          = (word_reg == SW_W'(LAST_WORD));
    assign start_out_of_range = (request.ident == '0) || (int'(request.ident) >= ID_COUNT);
    assign quot_word          = SW_W'(prod_reg >> DIV_SHIFT);
    assign rem_full           = ident_reg - (IDENT_W'(quot_word) * IDENT_W'(WORD_BITS));
    assign rem_bit            = BIT_W'(rem_full);
    assign bit_mask           = WORD_BITS'(1) << bit_reg;
    assign hit_mask           = WORD_BITS'(1) << hit_bit;
    assign grant_id           = ID_W'(grant_word_reg) * ID_W'(WORD_BITS) + ID_W'(grant_bit_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.operation)
                        OP_CLEAR:   state_next = S_CLEAR;
                        OP_ALLOC:   state_next = S_SCAN_RD;
                        default:    state_next = start_out_of_range ? S_DONE : S_DIV;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (word_last)
                begin
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
            end
            S_DIV:      state_next = S_RMW;
            S_RMW:      state_next = S_DONE;
            S_SCAN_RD:
            begin
                state_next = (word_reg >= SW_W'(WORD_COUNT)) ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    state_next = grant_phase_reg ? S_SCAN_RD : S_DONE;
                end
                else if (word_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        init_next        = init_reg;
        word_next        = word_reg;
        bit_next         = bit_reg;
        hint_word_next   = hint_word_reg;
        hint_bit_next    = hint_bit_reg;
        grant_phase_next = grant_phase_reg;
        done_next        = 1'b0;
        op_next          = op_reg;
        ident_next       = ident_reg;
        prod_next        = prod_reg;
        grant_word_next  = grant_word_reg;
        grant_bit_next   = grant_bit_reg;
        grant_ok_next    = grant_ok_reg;
        status_next      = status_reg;
        result_next      = result_reg;
        mem_we           = 1'b0;
        mem_waddr        = word_reg[WADDR_W-1:0];
        mem_wdata        = '0;
        mem_raddr        = word_reg[WADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next          = request.operation;
                    ident_next       = request.ident;
                    prod_next        = PROD_W'(request.ident) * PROD_W'(RECIP);
                    grant_ok_next    = 1'b0;
                    grant_phase_next = 1'b1;
                    status_next      = ST_OK;
                    case (request.operation)
                        OP_CLEAR:
                        begin
                            word_next = '0;
                        end
                        OP_ALLOC:
                        begin
                            word_next = hint_word_reg;
                            bit_next  = hint_bit_reg;
                        end
                        default:
                        begin
                            if (start_out_of_range)
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                word_next = word_reg + SW_W'(1);
                if (word_last)
                begin
                    init_next      = 1'b0;
                    hint_word_next = '0;
                    hint_bit_next  = BIT_W'(1);
                end
            end
            S_DIV:
            begin
                word_next = quot_word;
                bit_next  = rem_bit;
                mem_raddr = quot_word[WADDR_W-1:0];
                if ((op_reg == OP_FREE)
                    && ((quot_word < hint_word_reg)
                        || ((quot_word == hint_word_reg) && (rem_bit < hint_bit_reg))))
                begin
                    hint_word_next = quot_word;
                    hint_bit_next  = rem_bit;
                end
            end
            S_RMW:
            begin
                mem_we    = 1'b1;
                mem_wdata = (op_reg == OP_FREE) ? (rdata_reg & ~bit_mask)
                                                : (rdata_reg | bit_mask);
            end
            S_SCAN_RD:
            begin
                if (word_reg >= SW_W'(WORD_COUNT))
                begin
                    hint_word_next = SW_W'(END_WORD);
                    hint_bit_next  = BIT_W'(END_BIT);
                    if (grant_phase_reg)
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    if (grant_phase_reg)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = rdata_reg | hit_mask;
                        grant_word_next  = word_reg;
                        grant_bit_next   = hit_bit;
                        grant_ok_next    = 1'b1;
                        grant_phase_next = 1'b0;
                        if (hit_bit == BIT_W'(WORD_BITS - 1))
                        begin
                            word_next = word_reg + SW_W'(1);
                            bit_next  = '0;
                        end
                        else
                        begin
                            bit_next  = hit_bit + BIT_W'(1);
                        end
                    end
                    else
                    begin
                        hint_word_next = word_reg;
                        hint_bit_next  = hit_bit;
                    end
                end
                else if (word_last)
                begin
                    hint_word_next = SW_W'(END_WORD);
                    hint_bit_next  = BIT_W'(END_BIT);
                    if (grant_phase_reg)
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    word_next = word_reg + SW_W'(1);
                    bit_next  = '0;
                    mem_raddr = WADDR_W'(word_reg + SW_W'(1));
                end
            end
            S_DONE:
            begin
                done_next                 = 1'b1;
                result_next.status        = status_reg;
                result_next.granted_ident = grant_ok_reg ? IDENT_W'(grant_id) : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            init_reg        <= 1'b1;
            word_reg        <= '0;
            bit_reg         <= '0;
            hint_word_reg   <= '0;
            hint_bit_reg    <= BIT_W'(1);
            grant_phase_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_reg        <= init_next;
            word_reg        <= word_next;
            bit_reg         <= bit_next;
            hint_word_reg   <= hint_word_next;
            hint_bit_reg    <= hint_bit_next;
            grant_phase_reg <= grant_phase_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ident_reg      <= ident_next;
        prod_reg       <= prod_next;
        grant_word_reg <= grant_word_next;
        grant_bit_reg  <= grant_bit_next;
        grant_ok_reg   <= grant_ok_next;
        status_reg     <= status_next;
        result_reg     <= result_next;
    end

endmodule

// File: hdl/lfia_checker.sv
// ----------------------------------------------------------------------------
// Lowest free identifier allocator checker
// Port-level assertions on the allocator, attached by a bind statement.
// ----------------------------------------------------------------------------
module lfia_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input lfia_pkg::request_t request,
    input logic               done,
    input lfia_pkg::result_t  result
);

    import lfia_pkg::*;

    op_t last_op_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            last_op_reg <= OP_CLEAR;
        end else if (start && !busy) begin
            last_op_reg <= request.operation;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted item did not raise busy.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_failure_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.granted_ident == '0)
        else $error("Failed item carried a nonzero identifier.");

    a_full_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> last_op_reg == OP_ALLOC)
        else $error("Full status on an item that was not an allocate.");

    a_range_only_ident: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_RANGE |->
            (last_op_reg == OP_FREE || last_op_reg == OP_REGISTER))
        else $error("Range status on an item that takes no identifier.");

endmodule

bind lowest_free_id_allocator_unit lfia_checker u_lfia_checker (.*);

// File: dv/lfia_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocator result checker
// Watches the request and result channels of the identifier allocator. It
// keeps its own copy of the used map and the free hint, works out the grant
// and status of every accepted item, and compares each strobed result with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lfia_result_checker
    import lfia_pkg::*;
#(
    parameter int ID_COUNT = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     done,
    input  result_t  result,
    output int       mismatch_count,
    output int       pending
);

    logic [ID_COUNT-1:0] used_map;
    int unsigned         next_hint;
    result_t             expected_results[$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count = mismatch_count + 1;
    endtask

    function automatic int unsigned lowest_free(input int unsigned from);
        int unsigned i;
        for (i = (from < 1) ? 1 : from; i < ID_COUNT; i++)
        begin
            if (!used_map[i])
                return i;
        end
        return ID_COUNT;
    endfunction

    function automatic result_t predict_grant(input request_t req);
        result_t     res;
        int unsigned slot;
        res.granted_ident = '0;
        res.status        = ST_OK;
        case (req.operation)
            OP_CLEAR:
            begin
                used_map  = '0;
                next_hint = 1;
            end
            OP_ALLOC:
            begin
                slot = lowest_free(next_hint);
                if (slot >= ID_COUNT)
                begin
                    next_hint  = ID_COUNT;
                    res.status = ST_FULL;
                end
                else
                begin
                    used_map[slot]    = 1'b1;
                    res.granted_ident = slot[IDENT_W-1:0];
                    next_hint         = lowest_free(slot + 1);
                end
            end
            default:
            begin
                if (req.ident == 0 || req.ident >= ID_COUNT)
                    res.status = ST_RANGE;
                else if (req.operation == OP_FREE)
                begin
                    if (req.ident < next_hint)
                        next_hint = 32'(req.ident);
                    used_map[req.ident] = 1'b0;
                end
                else
                    used_map[req.ident] = 1'b1;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            used_map       = '0;
            next_hint      = 1;
            mismatch_count = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result strobe with no item outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (result.granted_ident !== want.granted_ident)
                        report_mismatch($sformatf("granted_ident %0d, expected %0d",
                            result.granted_ident, want.granted_ident));
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            result.status, want.status));
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_grant(request));
            pending <= expected_results.size();
        end
    end

endmodule

// File: dv/lowest_free_id_allocator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lowest free identifier allocator testbench
// Drives directed and random allocate, free, register and clear items with
// random idle gaps, including a run that fills the whole map, while the
// result checker predicts and compares every result.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_unit_test;
    import lfia_pkg::*;

    localparam int ID_COUNT = 1024;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    request_t request;
    result_t  result;
    int       mismatch_count;
    int       pending;
    bit       steady;

    lowest_free_id_allocator_unit #(
        .ID_COUNT (ID_COUNT)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    lfia_result_checker #(
        .ID_COUNT (ID_COUNT)
    ) result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [IDENT_W-1:0] pick_ident();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 13)
            return IDENT_W'(ID_COUNT - 1);
        if (roll < 28)
            return IDENT_W'($urandom);
        return IDENT_W'($urandom_range(1, 96));
    endfunction

    task automatic issue(input op_t op, input logic [IDENT_W-1:0] id);
        request_t    req;
        int unsigned gap;
        req.operation = op;
        req.ident     = id;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(0, 59) == 0)
            steady = !steady;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned roll;
        int          n;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        steady  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, 10'h3FF);
        issue(OP_REGISTER, 10'd3);
        issue(OP_ALLOC, '0);
        issue(OP_REGISTER, 10'd4);
        issue(OP_FREE, 10'd0);
        issue(OP_REGISTER, 10'd0);
        issue(OP_FREE, 10'd500);
        issue(OP_FREE, 10'd2);
        issue(OP_ALLOC, 10'h2AA);
        issue(OP_REGISTER, 10'd1023);
        issue(OP_FREE, 10'd1023);
        issue(OP_REGISTER, 10'h2AA);
        issue(OP_REGISTER, 10'h155);
        issue(OP_CLEAR, 10'h3FF);
        issue(OP_ALLOC, 10'h155);
        issue(OP_REGISTER, 10'd2);
        issue(OP_REGISTER, 10'd31);
        issue(OP_REGISTER, 10'd32);
        issue(OP_ALLOC, '0);
        issue(OP_ALLOC, '0);
        issue(OP_FREE, 10'd1);
        issue(OP_ALLOC, '0);
        drain();

        // Fill the whole map, then run into the full condition.
        issue(OP_CLEAR, IDENT_W'($urandom));
        for (n = 0; n < ID_COUNT - 1; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                issue(OP_REGISTER, IDENT_W'($urandom_range(1, ID_COUNT - 1)));
            issue(OP_ALLOC, IDENT_W'($urandom));
        end
        repeat (6) issue(OP_ALLOC, IDENT_W'($urandom));
        drain();
        repeat (3) issue(OP_FREE, IDENT_W'($urandom_range(1, ID_COUNT - 1)));
        repeat (4) issue(OP_ALLOC, IDENT_W'($urandom));
        issue(OP_REGISTER, IDENT_W'($urandom_range(1, ID_COUNT - 1)));
        issue(OP_ALLOC, IDENT_W'($urandom));

        for (n = 0; n < 280; n++)
        begin
            if (n == 140)
                drain();
            roll = $urandom_range(0, 99);
            if (roll < 2)
                issue(OP_CLEAR, IDENT_W'($urandom));
            else if (roll < 45)
                issue(OP_ALLOC, IDENT_W'($urandom));
            else if (roll < 72)
                issue(OP_FREE, pick_ident());
            else
                issue(OP_REGISTER, pick_ident());
        end

        drain();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
